### hdl/tgad_pkg.sv
package tgad_pkg;

   // result kinds carried on the result channel's tuser
   localparam logic [1:0] WHAT_PIXEL  = 2'd0;
   localparam logic [1:0] WHAT_HEADER = 2'd1;
   localparam logic [1:0] WHAT_REJECT = 2'd2;
   localparam logic [1:0] WHAT_DEPTH  = 2'd3;

   // header layout
   localparam int HDR_LAST = 17;
   localparam logic [7:0] IDX_CMT_LEN = 8'd0;
   localparam logic [7:0] IDX_CMAP    = 8'd1;
   localparam logic [7:0] IDX_TYPE    = 8'd2;
   localparam logic [7:0] IDX_W_LO    = 8'd12;
   localparam logic [7:0] IDX_W_HI    = 8'd13;
   localparam logic [7:0] IDX_H_LO    = 8'd14;
   localparam logic [7:0] IDX_H_HI    = 8'd15;
   localparam logic [7:0] IDX_DEPTH   = 8'd16;

   localparam logic [7:0] TYPE_RAW = 8'd2;
   localparam logic [7:0] TYPE_RLE = 8'd10;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;
   localparam int ORIGIN_BIT = 5;
   localparam int RUN_BIT    = 7;

   typedef struct packed {
      logic [1:0]  what;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [31:0] first_index;
      logic [7:0]  repeat_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        has_alpha;
      logic        bottom_up;
      logic        last;
   } result_type;

endpackage

### hdl/tgad_parser.sv
module tgad_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  logic                file_start,
   output logic                res_valid,
   output tgad_pkg::result_type res
);

   localparam logic [2:0] PH_HEADER  = 3'd0;
   localparam logic [2:0] PH_COMMENT = 3'd1;
   localparam logic [2:0] PH_PACKET  = 3'd2;
   localparam logic [2:0] PH_PIXEL   = 3'd3;
   localparam logic [2:0] PH_IDLE    = 3'd4;

   logic [2:0]  phase_ff, phase_in, phase_cur;
   logic [7:0]  cnt_ff, cnt_in, cnt_cur, cnt_inc;
   logic [7:0]  cmt_len_ff, cmt_len_in;
   logic        cmap_ff, cmap_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] w_ff, w_in;
   logic [7:0]  h_lo_ff, h_lo_in;
   logic [7:0]  h_hi_ff, h_hi_in;
   logic [7:0]  depth_ff, depth_in;
   logic        bottom_ff, bottom_in;
   logic [7:0]  pix0_ff, pix0_in, pix1_ff, pix1_in, pix2_ff, pix2_in;
   logic        run_ff, run_in;
   logic [7:0]  left_ff, left_in;
   logic [31:0] done_ff, done_in;
   logic [31:0] remain_ff, remain_in;

   logic [15:0] h_full;
   logic [31:0] area;
   logic        is_rle, is_32, hdr_rle, bad_format, bad_depth;
   logic [7:0]  rep_raw, rep, pix_last;
   logic        rep_clip, run_done;
   logic [7:0]  left_dec;
   logic [2:0]  data_phase;

   assign is_rle  = (type_ff == tgad_pkg::TYPE_RLE);
   assign is_32   = (depth_ff == tgad_pkg::DEPTH_32);
   assign h_full  = {h_hi_ff, h_lo_ff};
   assign area    = {16'd0, w_ff} * {16'd0, h_full};
   assign hdr_rle = is_rle;
   assign bad_format = cmap_ff
      || ((type_ff != tgad_pkg::TYPE_RAW) && (type_ff != tgad_pkg::TYPE_RLE))
      || (w_ff == 16'd0) || (h_full == 16'd0);
   assign bad_depth = (depth_ff != tgad_pkg::DEPTH_24) && (depth_ff != tgad_pkg::DEPTH_32);
   assign data_phase = hdr_rle ? PH_PACKET : PH_PIXEL;

   // a new file restarts the parser before this byte is taken
   assign phase_cur = file_start ? PH_HEADER : phase_ff;
   assign cnt_cur   = file_start ? 8'd0 : cnt_ff;
   assign cnt_inc   = cnt_cur + 8'd1;

   // run length, clipped to the pixels still owed
   assign rep_raw  = run_ff ? left_ff : 8'd1;
   assign rep_clip = (remain_ff[31:8] == 24'd0) && (remain_ff[7:0] < rep_raw);
   assign rep      = rep_clip ? remain_ff[7:0] : rep_raw;
   assign run_done = (remain_ff[31:8] == 24'd0) && (remain_ff[7:0] == rep);
   assign pix_last = is_32 ? 8'd3 : 8'd2;
   assign left_dec = (left_ff != 8'd0) ? left_ff - 8'd1 : 8'd0;

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      cmt_len_in = cmt_len_ff;
      cmap_in    = cmap_ff;
      type_in    = type_ff;
      w_in       = w_ff;
      h_lo_in    = h_lo_ff;
      h_hi_in    = h_hi_ff;
      depth_in   = depth_ff;
      bottom_in  = bottom_ff;
      pix0_in    = pix0_ff;
      pix1_in    = pix1_ff;
      pix2_in    = pix2_ff;
      run_in     = run_ff;
      left_in    = left_ff;
      done_in    = done_ff;
      remain_in  = remain_ff;
      res_valid  = 1'b0;
      res        = '0;
      if (step) begin
         phase_in = phase_cur;
         cnt_in   = cnt_cur;
         unique case (phase_cur)
            PH_HEADER: begin
               cnt_in = cnt_inc;
               unique case (cnt_cur)
                  tgad_pkg::IDX_CMT_LEN: cmt_len_in = data_byte;
                  tgad_pkg::IDX_CMAP:    cmap_in = (data_byte != 8'd0);
                  tgad_pkg::IDX_TYPE:    type_in = data_byte;
                  tgad_pkg::IDX_W_LO:    w_in[7:0] = data_byte;
                  tgad_pkg::IDX_W_HI:    w_in[15:8] = data_byte;
                  tgad_pkg::IDX_H_LO:    h_lo_in = data_byte;
                  tgad_pkg::IDX_H_HI:    h_hi_in = data_byte;
                  tgad_pkg::IDX_DEPTH:   depth_in = data_byte;
                  default: ;
               endcase
               if (cnt_cur == 8'(tgad_pkg::HDR_LAST)) begin
                  res_valid = 1'b1;
                  bottom_in = ~data_byte[tgad_pkg::ORIGIN_BIT];
                  remain_in = area;
                  done_in   = 32'd0;
                  cnt_in    = 8'd0;
                  priority if (bad_format) begin
                     res.what = tgad_pkg::WHAT_REJECT;
                     phase_in = PH_IDLE;
                  end else if (bad_depth) begin
                     res.what = tgad_pkg::WHAT_DEPTH;
                     phase_in = PH_IDLE;
                  end else begin
                     res.what         = tgad_pkg::WHAT_HEADER;
                     res.image_width  = w_ff;
                     res.image_height = h_full;
                     res.has_alpha    = is_32;
                     res.bottom_up    = ~data_byte[tgad_pkg::ORIGIN_BIT];
                     run_in  = 1'b0;
                     left_in = 8'd0;
                     phase_in = (cmt_len_ff == 8'd0) ? data_phase : PH_COMMENT;
                  end
               end
            end
            PH_COMMENT: begin
               cnt_in = cnt_inc;
               if (cnt_inc >= cmt_len_ff) begin
                  cnt_in   = 8'd0;
                  run_in   = 1'b0;
                  left_in  = 8'd0;
                  phase_in = data_phase;
               end
            end
            PH_PACKET: begin
               run_in   = data_byte[tgad_pkg::RUN_BIT];
               left_in  = {1'b0, data_byte[6:0]} + 8'd1;
               cnt_in   = 8'd0;
               phase_in = PH_PIXEL;
            end
            PH_PIXEL: begin
               cnt_in = cnt_inc;
               unique case (cnt_cur[1:0])
                  2'd0: pix0_in = data_byte;
                  2'd1: pix1_in = data_byte;
                  2'd2: pix2_in = data_byte;
                  default: ;
               endcase
               if (cnt_cur == pix_last) begin
                  res_valid        = 1'b1;
                  cnt_in           = 8'd0;
                  res.what         = tgad_pkg::WHAT_PIXEL;
                  res.red          = is_32 ? pix2_ff : data_byte;
                  res.green        = pix1_ff;
                  res.blue         = pix0_ff;
                  res.alpha        = is_32 ? data_byte : 8'd0;
                  res.first_index  = done_ff;
                  res.repeat_count = rep;
                  res.has_alpha    = is_32;
                  res.bottom_up    = bottom_ff;
                  res.last         = run_done;
                  done_in   = done_ff + {24'd0, rep};
                  remain_in = remain_ff - {24'd0, rep};
                  if (is_rle) begin
                     if (run_ff) begin
                        phase_in = PH_PACKET;
                     end else begin
                        left_in = left_dec;
                        if (left_dec == 8'd0) begin
                           phase_in = PH_PACKET;
                        end
                     end
                  end
                  if (run_done) begin
                     phase_in = PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         cnt_ff   <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmt_len_ff <= cmt_len_in;
      cmap_ff    <= cmap_in;
      type_ff    <= type_in;
      w_ff       <= w_in;
      h_lo_ff    <= h_lo_in;
      h_hi_ff    <= h_hi_in;
      depth_ff   <= depth_in;
      bottom_ff  <= bottom_in;
      pix0_ff    <= pix0_in;
      pix1_ff    <= pix1_in;
      pix2_ff    <= pix2_in;
      run_ff     <= run_in;
      left_ff    <= left_in;
      done_ff    <= done_in;
      remain_ff  <= remain_in;
   end

endmodule

### hdl/tgad_out_reg.sv
module tgad_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  tgad_pkg::result_type load_data,
   input  logic                 take,
   output logic                 space,
   output logic                 valid,
   output tgad_pkg::result_type data
);

   logic                 valid_ff, valid_in;
   tgad_pkg::result_type data_ff, data_in;

   // free when empty or when the held result leaves this cycle
   assign space    = ~valid_ff | take;
   assign valid_in = load | (valid_ff & ~take);
   assign data_in  = load ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

### hdl/tga_rle_stream_decoder.sv
// streaming decoder for truevision tga files (uncompressed and rle true-colour)
// req channel: one file byte per transfer in req_tdata, req_tuser set on the
//   first byte of a new file, which restarts the parser
// rsp channel: at most one result per input byte; rsp_tuser gives its kind
//   (pixel run, header accepted, format rejected, depth unsupported) and
//   rsp_tlast marks the run that completes the image
// the 18-byte header is checked on its last byte; the comment is skipped;
//   each pixel or rle run comes out with its first linear index and a count
// output: a result is registered and is on rsp in the cycle after the byte that completes it
// throughput: one byte per cycle while req_tready is high; each byte is
//   handled by one pass through the parser logic, the 16x16 size multiply
//   on the last header byte being the longest path
// reset: parser waits for header byte 0, result register is empty
// stalls: the result register holds one result; while it is full and
//   rsp_tready is low, req_tready is low, otherwise bytes keep flowing
// after a rejection or the final pixel, bytes are taken and dropped until
//   the next file start
module tga_rle_stream_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] file_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // red, green, blue, alpha, first_index,
                                     // repeat_count, image_width, image_height,
                                     // has_alpha, bottom_up, zero pad
   output logic [1:0]   rsp_tuser,   // [1:0] what
   output logic         rsp_tlast    // last
);

   logic                 step;
   logic                 space;
   logic                 res_valid;
   tgad_pkg::result_type res;
   tgad_pkg::result_type out;

   // a byte transfers only when the result register can take its result
   assign req_tready = space;
   assign step       = req_tvalid & space;

   tgad_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (req_tdata),
      .file_start(req_tuser),
      .res_valid (res_valid),
      .res       (res)
   );

   tgad_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (res_valid),
      .load_data(res),
      .take     (rsp_tready),
      .space    (space),
      .valid    (rsp_tvalid),
      .data     (out)
   );

   // pack fields from the lowest bit up
   assign rsp_tdata = {6'd0, out.bottom_up, out.has_alpha, out.image_height,
                       out.image_width, out.repeat_count, out.first_index,
                       out.alpha, out.blue, out.green, out.red};
   assign rsp_tuser = out.what;
   assign rsp_tlast = out.last;

endmodule

### dv/tga_rle_stream_checker.sv
module tga_rle_stream_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tuser,   // [0] file_start
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [111:0] rsp_tdata,   // red, green, blue, alpha, first_index,
                                     // repeat_count, image_width, image_height,
                                     // has_alpha, bottom_up, zero pad
   input  logic [1:0]   rsp_tuser,   // [1:0] what
   input  logic         rsp_tlast,   // last
   output int           fail_count,
   output int           waiting,
   output int           checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PARSE_HEADER,
      PARSE_COMMENT,
      PARSE_PACKET,
      PARSE_PIXEL,
      PARSE_IDLE
   } parse_phase_type;

   parse_phase_type parse_phase;
   logic [7:0]   byte_pos;
   logic [7:0]   hdr [256];
   logic [7:0]   pix [4];
   logic [7:0]   packet_count;
   logic         in_run;
   logic [31:0]  emitted;
   logic [31:0]  image_size;

   tgad_pkg::result_type expected_results [$];

   function void clear_parser();
      parse_phase  = PARSE_HEADER;
      byte_pos     = '0;
      packet_count = '0;
      in_run       = 1'b0;
      emitted      = '0;
      image_size   = '0;
      foreach (hdr[i]) hdr[i] = '0;
      foreach (pix[i]) pix[i] = '0;
   endfunction

   function void start_pixels();
      byte_pos     = '0;
      in_run       = 1'b0;
      packet_count = '0;
      parse_phase  = (hdr[tgad_pkg::IDX_TYPE] == tgad_pkg::TYPE_RLE) ? PARSE_PACKET
                                                                     : PARSE_PIXEL;
   endfunction

   // expected result, if any, of one accepted file byte
   function void decode_byte(logic [7:0] value, logic restart);
      tgad_pkg::result_type r;
      logic [15:0] width;
      logic [15:0] height;
      logic [31:0] count;
      logic        deep;
      logic        rle;
      logic [7:0]  desc;
      r = '0;
      if (restart) clear_parser();
      deep = (hdr[tgad_pkg::IDX_DEPTH] == tgad_pkg::DEPTH_32);
      rle  = (hdr[tgad_pkg::IDX_TYPE] == tgad_pkg::TYPE_RLE);
      desc = hdr[8'(tgad_pkg::HDR_LAST)];
      case (parse_phase)
         PARSE_HEADER: begin
            hdr[byte_pos] = value;
            byte_pos++;
            if (byte_pos > 8'(tgad_pkg::HDR_LAST)) begin
               width      = {hdr[tgad_pkg::IDX_W_HI], hdr[tgad_pkg::IDX_W_LO]};
               height     = {hdr[tgad_pkg::IDX_H_HI], hdr[tgad_pkg::IDX_H_LO]};
               image_size = 32'(width) * 32'(height);
               deep       = (hdr[tgad_pkg::IDX_DEPTH] == tgad_pkg::DEPTH_32);
               desc       = hdr[8'(tgad_pkg::HDR_LAST)];
               if (hdr[tgad_pkg::IDX_CMAP] != 8'd0 || image_size == 0 ||
                   (hdr[tgad_pkg::IDX_TYPE] != tgad_pkg::TYPE_RAW &&
                    hdr[tgad_pkg::IDX_TYPE] != tgad_pkg::TYPE_RLE)) begin
                  r.what      = tgad_pkg::WHAT_REJECT;
                  parse_phase = PARSE_IDLE;
               end else if (hdr[tgad_pkg::IDX_DEPTH] != tgad_pkg::DEPTH_24 && !deep) begin
                  r.what      = tgad_pkg::WHAT_DEPTH;
                  parse_phase = PARSE_IDLE;
               end else begin
                  r.what         = tgad_pkg::WHAT_HEADER;
                  r.image_width  = width;
                  r.image_height = height;
                  r.has_alpha    = deep;
                  r.bottom_up    = !desc[tgad_pkg::ORIGIN_BIT];
                  byte_pos       = '0;
                  if (hdr[tgad_pkg::IDX_CMT_LEN] == 8'd0) start_pixels();
                  else parse_phase = PARSE_COMMENT;
               end
               expected_results.push_back(r);
            end
         end
         PARSE_COMMENT: begin
            byte_pos++;
            if (byte_pos >= hdr[tgad_pkg::IDX_CMT_LEN]) start_pixels();
         end
         PARSE_PACKET: begin
            in_run       = value[tgad_pkg::RUN_BIT];
            packet_count = {1'b0, value[6:0]} + 8'd1;
            byte_pos     = '0;
            parse_phase  = PARSE_PIXEL;
         end
         PARSE_PIXEL: begin
            pix[byte_pos[1:0]] = value;
            byte_pos++;
            if (byte_pos >= (deep ? 8'd4 : 8'd3)) begin
               byte_pos = '0;
               // a run or raw packet is cut at the image end
               count = in_run ? 32'(packet_count) : 32'd1;
               if (count > image_size - emitted) count = image_size - emitted;
               r.what         = tgad_pkg::WHAT_PIXEL;
               r.red          = pix[2];
               r.green        = pix[1];
               r.blue         = pix[0];
               r.alpha        = deep ? pix[3] : 8'd0;
               r.first_index  = emitted;
               r.repeat_count = count[7:0];
               r.has_alpha    = deep;
               r.bottom_up    = !desc[tgad_pkg::ORIGIN_BIT];
               emitted += count;
               if (rle) begin
                  if (in_run) begin
                     parse_phase = PARSE_PACKET;
                  end else begin
                     if (packet_count != 0) packet_count--;
                     if (packet_count == 0) parse_phase = PARSE_PACKET;
                  end
               end
               if (emitted >= image_size) begin
                  r.last      = 1'b1;
                  parse_phase = PARSE_IDLE;
               end
               expected_results.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   task report_error(string msg);
      $display("%t ERROR %s", $realtime, msg);
      fail_count++;
   endtask

   task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_error($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
   endtask

   task check_result();
      tgad_pkg::result_type want;
      if (expected_results.size() == 0) begin
         report_error($sformatf("result %0d: none expected, got kind %0d", checked, rsp_tuser));
      end else begin
         want = expected_results.pop_front();
         compare_field("what", 32'(rsp_tuser), 32'(want.what));
         compare_field("red", 32'(rsp_tdata[7:0]), 32'(want.red));
         compare_field("green", 32'(rsp_tdata[15:8]), 32'(want.green));
         compare_field("blue", 32'(rsp_tdata[23:16]), 32'(want.blue));
         compare_field("alpha", 32'(rsp_tdata[31:24]), 32'(want.alpha));
         compare_field("first_index", rsp_tdata[63:32], want.first_index);
         compare_field("repeat_count", 32'(rsp_tdata[71:64]), 32'(want.repeat_count));
         compare_field("image_width", 32'(rsp_tdata[87:72]), 32'(want.image_width));
         compare_field("image_height", 32'(rsp_tdata[103:88]), 32'(want.image_height));
         compare_field("has_alpha", 32'(rsp_tdata[104]), 32'(want.has_alpha));
         compare_field("bottom_up", 32'(rsp_tdata[105]), 32'(want.bottom_up));
         compare_field("last", 32'(rsp_tlast), 32'(want.last));
      end
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tuser);
      end
      waiting <= expected_results.size();
   end

endmodule

### dv/tga_rle_stream_decoder_test.sv
module tga_rle_stream_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILE_BYTES  = 1500;  // stimulus stops after about this many bytes
   localparam int QUIET_AFTER = 1300;  // no idling on either side past this point

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;  // [7:0] data_byte
   logic         req_tuser  = 1'b0;   // [0] file_start
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;           // red, green, blue, alpha, first_index,
                                      // repeat_count, image_width, image_height,
                                      // has_alpha, bottom_up, zero pad
   logic [1:0]   rsp_tuser;           // [1:0] what
   logic         rsp_tlast;           // last

   int fail_count;
   int waiting;
   int checked;

   bit         gaps_on    = 1'b0;  // idling allowed for the current file
   int         stall_left = 0;
   int         bytes_sent = 0;
   int         files_sent = 0;
   logic [7:0] file_bytes [$];     // bytes of the file being built

   always #6 clock = ~clock;

   tga_rle_stream_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tga_rle_stream_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .waiting    (waiting),
      .checked    (checked)
   );

   // result side back-pressure: random rsp_tready stalls while idling is on
   always @(posedge clock) begin
      if (!gaps_on) begin
         rsp_tready <= 1'b1;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // 18-byte header, little-endian sizes, then the comment
   function void put_header(logic [7:0] cmt_len, logic [7:0] cmap, logic [7:0] kind,
                            logic [15:0] width, logic [15:0] height,
                            logic [7:0] depth, logic [7:0] desc);
      file_bytes.push_back(cmt_len);
      file_bytes.push_back(cmap);
      file_bytes.push_back(kind);
      repeat (9) file_bytes.push_back(8'($urandom));  // colormap spec and origin, unused
      file_bytes.push_back(width[7:0]);
      file_bytes.push_back(width[15:8]);
      file_bytes.push_back(height[7:0]);
      file_bytes.push_back(height[15:8]);
      file_bytes.push_back(depth);
      file_bytes.push_back(desc);
      repeat (cmt_len) file_bytes.push_back(8'($urandom));
   endfunction

   // pixel data for npix pixels; rle packets sometimes overshoot the image end
   function void put_pixels(logic [7:0] kind, logic [7:0] depth, int unsigned npix);
      int unsigned left;
      int unsigned n;
      int unsigned bpp;
      bpp  = (depth == tgad_pkg::DEPTH_32) ? 4 : 3;
      left = npix;
      while (left > 0) begin
         if (kind == tgad_pkg::TYPE_RLE) begin
            if ($urandom_range(0, 5) == 0) n = $urandom_range(1, 128);
            else n = $urandom_range(1, (left < 12) ? left : 12);
            if ($urandom_range(0, 1) == 1) begin
               file_bytes.push_back({1'b1, 7'(n - 1)});
               repeat (bpp) file_bytes.push_back(8'($urandom));
            end else begin
               file_bytes.push_back({1'b0, 7'(n - 1)});
               repeat (bpp * ((n < left) ? n : left)) file_bytes.push_back(8'($urandom));
            end
         end else begin
            n = 1;
            repeat (bpp) file_bytes.push_back(8'($urandom));
         end
         left = (n < left) ? left - n : 0;
      end
   endfunction

   // one transfer on the byte channel, with an occasional idle burst before it
   task send_byte(logic [7:0] value, logic start);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // sends the first keep bytes of the built file, the rest is dropped
   task send_file(logic start, int keep);
      int n;
      n = (keep < file_bytes.size()) ? keep : file_bytes.size();
      for (int i = 0; i < n; i++) send_byte(file_bytes[i], start && i == 0);
      file_bytes.delete();
      files_sent++;
   endtask

   // mostly well-formed small images with random content; some noise headers,
   // some files cut short, some with stray bytes after the image
   task random_file();
      logic [7:0]  cmt_len;
      logic [7:0]  cmap;
      logic [7:0]  kind;
      logic [7:0]  depth;
      logic [7:0]  desc;
      logic [15:0] width;
      logic [15:0] height;
      int unsigned npix;
      int          keep;
      cmt_len = ($urandom_range(0, 40) == 0) ? 8'd255 : 8'($urandom_range(0, 6));
      desc    = 8'($urandom);
      if ($urandom_range(0, 7) != 0) begin
         cmap  = 8'd0;
         kind  = ($urandom_range(0, 1) == 1) ? tgad_pkg::TYPE_RLE : tgad_pkg::TYPE_RAW;
         depth = ($urandom_range(0, 1) == 1) ? tgad_pkg::DEPTH_32 : tgad_pkg::DEPTH_24;
         if ($urandom_range(0, 19) == 0) begin
            // huge image, only its first pixels ever arrive
            width  = 16'($urandom_range(1, 16'hFFFF));
            height = 16'($urandom_range(1, 16'hFFFF));
         end else begin
            width  = 16'($urandom_range(1, 6));
            height = 16'($urandom_range(1, 4));
         end
      end else begin
         cmap  = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0;
         kind  = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 11)) : 8'($urandom);
         case ($urandom_range(0, 3))
            0: begin
               depth = 8'd16;
            end
            1: begin
               depth = tgad_pkg::DEPTH_24;
            end
            2: begin
               depth = tgad_pkg::DEPTH_32;
            end
            default: begin
               depth = 8'($urandom);
            end
         endcase
         width  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
         height = 16'($urandom_range(0, 3));
      end
      put_header(cmt_len, cmap, kind, width, height, depth, desc);
      npix = 32'(width) * 32'(height);
      if (npix > 40) npix = 40;
      put_pixels(kind, depth, npix);
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
      keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, file_bytes.size())
                                         : file_bytes.size();
      gaps_on = (bytes_sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
      send_file(1'b1, keep);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // first file with no start flag after reset, raw 24-bit 1x1 top-down,
      // then stray bytes that the finished parser must drop
      put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'd1, 16'd1, tgad_pkg::DEPTH_24, 8'h20);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h5A);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h00);
      send_file(1'b0, file_bytes.size());

      // colormap present outranks the bad depth
      put_header(8'd0, 8'd1, tgad_pkg::TYPE_RLE, 16'd2, 16'd2, 8'd16, 8'h00);
      send_file(1'b1, file_bytes.size());

      // unknown image type, bytes after the rejection are dropped
      put_header(8'd0, 8'd0, 8'd3, 16'd2, 16'd2, tgad_pkg::DEPTH_24, 8'h00);
      file_bytes.push_back(8'hA5);
      send_file(1'b1, file_bytes.size());

      // zero height with the widest width
      put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'hFFFF, 16'd0, tgad_pkg::DEPTH_32, 8'h00);
      send_file(1'b1, file_bytes.size());

      // depth unsupported
      put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'd1, 16'd1, 8'd16, 8'h20);
      send_file(1'b1, file_bytes.size());

      // rle 32-bit with a comment; a 128-pixel run clipped to 3
      put_header(8'd3, 8'd0, tgad_pkg::TYPE_RLE, 16'd3, 16'd1, tgad_pkg::DEPTH_32, 8'h00);
      file_bytes.push_back(8'hFF);
      file_bytes.push_back(8'h10);
      file_bytes.push_back(8'h20);
      file_bytes.push_back(8'h30);
      file_bytes.push_back(8'h40);
      send_file(1'b1, file_bytes.size());

      // rle 24-bit raw packet longer than the image
      put_header(8'd0, 8'd0, tgad_pkg::TYPE_RLE, 16'd2, 16'd1, tgad_pkg::DEPTH_24, 8'hDF);
      file_bytes.push_back(8'h7F);
      repeat (6) file_bytes.push_back(8'($urandom));
      send_file(1'b1, file_bytes.size());

      // largest image, cut short by the next file start
      put_header(8'd0, 8'd0, tgad_pkg::TYPE_RAW, 16'hFFFF, 16'hFFFF, tgad_pkg::DEPTH_32,
                 8'hFF);
      repeat (8) file_bytes.push_back(8'($urandom));
      send_file(1'b1, file_bytes.size());

      while (bytes_sent < FILE_BYTES) random_file();
      req_tvalid <= 1'b0;

      // drain: wait for every expected result, then a few cycles for strays
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("%0d file bytes in %0d files sent, %0d results compared", bytes_sent,
               files_sent, checked);
      $display("raw and rle images, rejections, clipped runs and cut-short files were covered");
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // overall run limit, far above the slowest correct run
   initial begin
      #5ms;
      $display("timeout with %0d results outstanding", waiting);
      $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
hdl/tgad_pkg.sv
hdl/tgad_parser.sv
hdl/tgad_out_reg.sv
hdl/tga_rle_stream_decoder.sv
dv/tga_rle_stream_checker.sv
dv/tga_rle_stream_decoder_test.sv
